// File: src/dqc_pkg.sv
// ----------------------------------------------------------------------------
// dqc_pkg
// Shared sizes, codes and types for the double-ended queue core.
// ----------------------------------------------------------------------------
package dqc_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam int ACT_W = 3;
  localparam int VAL_W = 8;
  localparam int ST_W  = 2;
  localparam int OCC_W = 5;

  localparam int IN_W  = 16;
  localparam int OUT_W = 16;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_REAR  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_REAR   = 3'd3,
    ACT_PEEK_FRONT = 3'd4,
    ACT_PEEK_REAR  = 3'd5
  } action_t;

  typedef enum logic [ST_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_RESP = 1'b1
  } fsm_t;

endpackage

// File: src/dqc_ram.sv
// ----------------------------------------------------------------------------
// dqc_ram
// Simple dual-port slot store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module dqc_ram #(
  parameter int ENTRIES = 16,
  parameter int AW      = 4,
  parameter int DW      = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/double_ended_queue_core.sv
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Bounded double-ended byte queue kept in a ring store with head and count.
// ----------------------------------------------------------------------------
// Input item (in_tdata): action (push/pop/peek at front or rear) and a byte.
// Result item (out_tdata): the byte popped or peeked, a status code and the
// occupancy after the request; exactly one result per input item.
// Head, count and the slot write are updated at the edge the item is taken;
// the slot read is issued at that same edge into the registered store output,
// the result register loads once the result side is free. With the result
// side taking every item, one item is accepted per cycle; the single pending
// result stage between store and result register sets that figure.
// A push into a full queue is refused with status full, a pop or peek of an
// empty queue returns zero with status empty, unused actions do nothing.
// Reset empties the queue (head and count to zero); slot contents are left.
// While the receiver stalls the result is held, one further item may be
// taken and its read held in the store output, then in_tready drops.
// ----------------------------------------------------------------------------
module double_ended_queue_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [dqc_pkg::IN_W-1:0]  in_tdata,   // action[2:0], push_value[10:3]
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [dqc_pkg::OUT_W-1:0] out_tdata   // read_value[7:0], status[9:8],
                                                // occupancy[14:10]
);

  logic [dqc_pkg::ACT_W-1:0] action;
  logic [dqc_pkg::VAL_W-1:0] push_value;

  dqc_pkg::fsm_t             state_r, state_nxt;
  logic [dqc_pkg::IDX_W-1:0] head_r, head_nxt;
  logic [dqc_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                      use_rd_r, use_rd_nxt;
  logic [dqc_pkg::ST_W-1:0]  st_r, st_nxt;
  logic [dqc_pkg::CNT_W-1:0] occ_r;
  logic                      out_valid_r;
  logic [dqc_pkg::OUT_W-1:0] out_data_r, out_data_nxt;

  logic                      in_acc, out_free, out_load;
  logic                      full, empty;
  logic [dqc_pkg::IDX_W-1:0] head_dec, head_inc, rear_idx, tail_idx;
  logic [dqc_pkg::IDX_W:0]   sum_rear, sum_tail;
  logic                      we, re;
  logic [dqc_pkg::IDX_W-1:0] waddr, raddr;
  logic [dqc_pkg::VAL_W-1:0] rdata;

  assign action     = in_tdata[dqc_pkg::ACT_W-1:0];
  assign push_value = in_tdata[dqc_pkg::ACT_W +: dqc_pkg::VAL_W];

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == dqc_pkg::FSM_IDLE) || out_free;
  assign in_acc    = in_tvalid && in_tready;
  assign out_load  = (state_r == dqc_pkg::FSM_RESP) && out_free;

  assign full  = (cnt_r == dqc_pkg::CNT_W'(dqc_pkg::DEPTH));
  assign empty = (cnt_r == '0);

  // ring index arithmetic, sums stay below twice the depth
  assign head_dec = (head_r == '0) ? dqc_pkg::IDX_W'(dqc_pkg::DEPTH - 1)
                                   : head_r - 1'b1;
  assign head_inc = (head_r == dqc_pkg::IDX_W'(dqc_pkg::DEPTH - 1)) ? '0
                                   : head_r + 1'b1;
  assign sum_tail = {1'b0, head_r} + (dqc_pkg::IDX_W+1)'(cnt_r);
  assign sum_rear = sum_tail - 1'b1;
  assign tail_idx = (sum_tail >= (dqc_pkg::IDX_W+1)'(dqc_pkg::DEPTH))
                  ? dqc_pkg::IDX_W'(sum_tail - (dqc_pkg::IDX_W+1)'(dqc_pkg::DEPTH))
                  : dqc_pkg::IDX_W'(sum_tail);
  assign rear_idx = (sum_rear >= (dqc_pkg::IDX_W+1)'(dqc_pkg::DEPTH))
                  ? dqc_pkg::IDX_W'(sum_rear - (dqc_pkg::IDX_W+1)'(dqc_pkg::DEPTH))
                  : dqc_pkg::IDX_W'(sum_rear);

  always_comb begin
    head_nxt   = head_r;
    cnt_nxt    = cnt_r;
    use_rd_nxt = use_rd_r;
    st_nxt     = st_r;
    we         = 1'b0;
    re         = 1'b0;
    waddr      = tail_idx;
    raddr      = head_r;
    if (in_acc) begin
      use_rd_nxt = 1'b0;
      st_nxt     = dqc_pkg::STAT_OK;
      case (action)
        dqc_pkg::ACT_PUSH_FRONT: begin
          if (full) begin
            st_nxt = dqc_pkg::STAT_FULL;
          end else begin
            we       = 1'b1;
            waddr    = head_dec;
            head_nxt = head_dec;
            cnt_nxt  = cnt_r + 1'b1;
          end
        end
        dqc_pkg::ACT_PUSH_REAR: begin
          if (full) begin
            st_nxt = dqc_pkg::STAT_FULL;
          end else begin
            we      = 1'b1;
            waddr   = tail_idx;
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        dqc_pkg::ACT_POP_FRONT, dqc_pkg::ACT_PEEK_FRONT: begin
          if (empty) begin
            st_nxt = dqc_pkg::STAT_EMPTY;
          end else begin
            re         = 1'b1;
            raddr      = head_r;
            use_rd_nxt = 1'b1;
            if (action == dqc_pkg::ACT_POP_FRONT) begin
              head_nxt = head_inc;
              cnt_nxt  = cnt_r - 1'b1;
            end
          end
        end
        dqc_pkg::ACT_POP_REAR, dqc_pkg::ACT_PEEK_REAR: begin
          if (empty) begin
            st_nxt = dqc_pkg::STAT_EMPTY;
          end else begin
            re         = 1'b1;
            raddr      = rear_idx;
            use_rd_nxt = 1'b1;
            if (action == dqc_pkg::ACT_POP_REAR) begin
              cnt_nxt = cnt_r - 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dqc_pkg::FSM_IDLE: begin
        if (in_acc) begin
          state_nxt = dqc_pkg::FSM_RESP;
        end
      end
      dqc_pkg::FSM_RESP: begin
        if (out_free && !in_acc) begin
          state_nxt = dqc_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_nxt = dqc_pkg::FSM_IDLE;
      end
    endcase
  end

  always_comb begin
    out_data_nxt = out_data_r;
    if (out_load) begin
      out_data_nxt = {1'b0, dqc_pkg::OCC_W'(occ_r), st_r,
                      use_rd_r ? rdata : dqc_pkg::VAL_W'(0)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dqc_pkg::FSM_IDLE;
      head_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      cnt_r   <= cnt_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    use_rd_r   <= use_rd_nxt;
    st_r       <= st_nxt;
    out_data_r <= out_data_nxt;
    if (in_acc) begin
      occ_r <= cnt_nxt;
    end
  end

  dqc_ram #(
    .ENTRIES (dqc_pkg::DEPTH),
    .AW      (dqc_pkg::IDX_W),
    .DW      (dqc_pkg::VAL_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (push_value),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
